@@ hdl/npl_pkg.sv @@
`default_nettype none
package npl_pkg;

  localparam int unsigned CHAR_BITS  = 8;
  localparam int unsigned VALUE_BITS = 64;

  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_BITS-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_BITS-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_BITS-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UF     = 8'h46;
  localparam logic [CHAR_BITS-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h66;

  localparam logic [3:0] DIG_ONE   = 4'd1;
  localparam logic [3:0] DIG_SEVEN = 4'd7;
  localparam logic [3:0] DIG_NINE  = 4'd9;
  localparam logic [3:0] DIG_TEN   = 4'd10;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2,
    BASE_OCT = 2'd3
  } base_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NODIGITS = 2'd2,
    ST_BADDIGIT = 2'd3
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } digit_t;

  function automatic digit_t decode_digit(input logic [CHAR_BITS-1:0] c, input base_t base);
    digit_t     r;
    logic       is_digit;
    logic [3:0] d;
    is_digit = 1'b1;
    d        = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = 4'(c - CH_LA) + DIG_TEN;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = 4'(c - CH_UA) + DIG_TEN;
    end else begin
      is_digit = 1'b0;
    end
    r.digit = d;
    case (base)
      BASE_HEX: r.ok = is_digit;
      BASE_BIN: r.ok = is_digit && (d <= DIG_ONE);
      BASE_OCT: r.ok = is_digit && (d <= DIG_SEVEN);
      BASE_DEC: r.ok = is_digit && (d <= DIG_NINE);
      default:  r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/npl_in_if.sv @@
`default_nettype none
interface npl_in_if import npl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

@@ hdl/npl_out_if.sv @@
`default_nettype none
interface npl_out_if import npl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  status_t               status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

@@ hdl/prefixed_number_literal_parser_top.sv @@
// a character beat is registered, then decoded and folded into the accumulator;
// a NUL beat instead has its result registered into the result register
// throughput: one character per cycle, sustained while the result side takes beats
// the step is one decode plus a shift-add multiply by the base and a digit add
// reset (rst_n low, synchronous): parser awaits a new literal, accumulator cleared,
// input and result registers empty
`default_nettype none
module prefixed_number_literal_parser_top import npl_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  npl_in_if.sink     in_chan,
  npl_out_if.source  out_chan
);

  logic                   s1_valid_r;
  logic [CHAR_BITS-1:0]   s1_char_r;
  logic                   at_start_r, at_start_nxt;
  base_t                  base_r, base_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   seen_r, seen_nxt;
  logic                   bad_r, bad_nxt;
  logic                   out_valid_r;
  logic [VALUE_BITS-1:0]  out_value_r, out_value_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   s1_nul;
  logic                   s1_fire;
  base_t                  dig_base;
  logic [VALUE_WIDTH-1:0] dig_acc;
  logic [VALUE_WIDTH-1:0] scaled;
  digit_t                 dig;

  assign s1_nul  = (s1_char_r == CH_NUL);
  assign s1_fire = s1_valid_r && (!s1_nul || !out_valid_r || out_chan.ready);

  assign in_chan.ready   = !s1_valid_r || s1_fire;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.value  = out_value_r;
  assign out_chan.status = out_status_r;

  // the first character of a literal, unless it is a $, % or @ prefix, folds into a fresh decimal accumulator
  assign dig_base = at_start_r ? BASE_DEC : base_r;
  assign dig_acc  = at_start_r ? '0 : acc_r;
  assign dig      = decode_digit(s1_char_r, dig_base);

  always_comb begin
    case (dig_base)
      BASE_HEX: scaled = dig_acc << 4;
      BASE_BIN: scaled = dig_acc << 1;
      BASE_OCT: scaled = dig_acc << 3;
      BASE_DEC: scaled = (dig_acc << 3) + (dig_acc << 1);
      default:  scaled = '0;
    endcase
  end

  always_comb begin
    at_start_nxt   = at_start_r;
    base_nxt       = base_r;
    acc_nxt        = acc_r;
    seen_nxt       = seen_r;
    bad_nxt        = bad_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    if (s1_nul) begin
      if (at_start_r) begin
        out_status_nxt = ST_EMPTY;
      end else if (bad_r) begin
        out_status_nxt = ST_BADDIGIT;
      end else if (!seen_r) begin
        out_status_nxt = ST_NODIGITS;
      end else begin
        out_value_nxt = VALUE_BITS'(acc_r);
      end
      at_start_nxt = 1'b1;
      base_nxt     = BASE_DEC;
      acc_nxt      = '0;
      seen_nxt     = 1'b0;
      bad_nxt      = 1'b0;
    end else if (at_start_r && (s1_char_r == CH_DOLLAR || s1_char_r == CH_PCT ||
                                s1_char_r == CH_AT)) begin
      at_start_nxt = 1'b0;
      acc_nxt      = '0;
      seen_nxt     = 1'b0;
      bad_nxt      = 1'b0;
      case (s1_char_r)
        CH_DOLLAR: base_nxt = BASE_HEX;
        CH_PCT:    base_nxt = BASE_BIN;
        default:   base_nxt = BASE_OCT;
      endcase
    end else if (at_start_r || !bad_r) begin
      at_start_nxt = 1'b0;
      base_nxt     = dig_base;
      if (dig.ok) begin
        acc_nxt  = scaled + VALUE_WIDTH'(dig.digit);
        seen_nxt = 1'b1;
        bad_nxt  = 1'b0;
      end else begin
        acc_nxt  = dig_acc;
        seen_nxt = at_start_r ? 1'b0 : seen_r;
        bad_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_char_r <= in_chan.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      base_r     <= BASE_DEC;
      acc_r      <= '0;
      seen_r     <= 1'b0;
      bad_r      <= 1'b0;
    end else if (s1_fire) begin
      at_start_r <= at_start_nxt;
      base_r     <= base_nxt;
      acc_r      <= acc_nxt;
      seen_r     <= seen_nxt;
      bad_r      <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_nul) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_nul) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_nul) |=> (at_start_r && out_valid_r))
    else $error("nul beat did not restart the parser");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error result carries a nonzero value");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    at_start_r |-> (!seen_r && !bad_r && acc_r == '0))
    else $error("parser awaiting a literal holds stale state");
`endif

endmodule
`default_nettype wire
